// ===== hdl/utgl_pkg.sv =====
// Shared types, sizes and helpers for the UTF-8 text grid layout block.
// Used by utgl_front, utgl_queue, utgl_back and the top level; depends on nothing.

package utgl_pkg;

  // Grid capacity in cells.
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 32;

  // Index widths into the grid, and cursor widths that can also hold the limit itself.
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCOL_W = $clog2(MAX_COLS + 1);
  localparam int CROW_W = $clog2(MAX_ROWS + 1);
  localparam int ADDR_W = ROW_W + COL_W;

  // Width used for mixed-width comparisons against the limits.
  localparam int CMP_W = 10;

  // Field widths of the ports.
  localparam int CP_W       = 21;
  localparam int COLS_W     = 7;
  localparam int ROWS_W     = 6;
  localparam int CFG_W      = 7;
  localparam int BYTE_W     = 8;
  localparam int CELL_COL_W = 6;
  localparam int CELL_ROW_W = 5;

  // Request codes on the input channel.
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [COLS_W-1:0] COLUMNS_RESET = 7'd32;
  localparam logic [ROWS_W-1:0] ROWS_RESET    = 6'd16;

  // Codepoints with a layout meaning.
  localparam logic [CP_W-1:0] SPACE_CP   = 21'h20;
  localparam logic [CP_W-1:0] NEWLINE_CP = 21'h0A;
  localparam logic [CP_W-1:0] TAB_CP     = 21'h09;
  localparam int              TAB_STEP   = 4;

  // Queue between the decoder and the layout engine.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_CP,
    OP_ERR,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t                kind;
    logic [CP_W-1:0]         cp;
    logic [CELL_COL_W-1:0]   col;
    logic [CELL_ROW_W-1:0]   row;
  } op_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  // Column count in use, clamped to 1..MAX_COLS.
  function automatic logic [CCOL_W-1:0] used_cols(input logic [COLS_W-1:0] c);
    logic [CMP_W-1:0] w;
    w = CMP_W'(c);
    if (w == '0) begin
      return CCOL_W'(1);
    end else if (w > CMP_W'(MAX_COLS)) begin
      return CCOL_W'(MAX_COLS);
    end else begin
      return CCOL_W'(w);
    end
  endfunction

  // Row count in use, clamped to 1..MAX_ROWS.
  function automatic logic [CROW_W-1:0] used_rows(input logic [ROWS_W-1:0] r);
    logic [CMP_W-1:0] w;
    w = CMP_W'(r);
    if (w == '0) begin
      return CROW_W'(1);
    end else if (w > CMP_W'(MAX_ROWS)) begin
      return CROW_W'(MAX_ROWS);
    end else begin
      return CROW_W'(w);
    end
  endfunction

endpackage

// ===== hdl/utgl_front.sv =====
// Front end of the text grid layout: takes requests and decodes UTF-8 bytes into
// codepoint, error, clear and read operations for the queue. Depends on utgl_pkg.

module utgl_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [utgl_pkg::BYTE_W-1:0]   in_text_byte,
  input  logic [utgl_pkg::CELL_COL_W-1:0] in_cell_col,
  input  logic [utgl_pkg::CELL_ROW_W-1:0] in_cell_row,
  input  logic                          q_full,
  input  utgl_pkg::back_status_t        back_status,
  output logic                          push,
  output utgl_pkg::op_t                 push_op
);

  localparam int CP_W = utgl_pkg::CP_W;

  // Lead and tail byte patterns.
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;
  localparam logic [7:0] LEAD4_BITS = 8'h07;
  localparam logic [7:0] TAIL_MASK  = 8'hC0;
  localparam logic [7:0] TAIL_VAL   = 8'h80;

  logic            accept;
  logic [CP_W-1:0] accum_r;
  logic [CP_W-1:0] accum_nxt;
  logic [CP_W-1:0] tail_acc;
  logic [1:0]      tails_r;
  logic [1:0]      tails_nxt;
  logic            err_seen_r;
  logic            err_seen_nxt;

  assign in_stall = q_full | back_status.clearing;
  assign accept   = in_valid & ~in_stall;
  assign tail_acc = {accum_r[CP_W-7:0], in_text_byte[5:0]};

  always_comb begin
    accum_nxt     = accum_r;
    tails_nxt     = tails_r;
    err_seen_nxt  = err_seen_r;
    push          = 1'b0;
    push_op.kind  = utgl_pkg::OP_CP;
    push_op.cp    = '0;
    push_op.col   = in_cell_col;
    push_op.row   = in_cell_row;
    if (accept) begin
      case (in_action)
        utgl_pkg::ACT_CLEAR: begin
          push         = 1'b1;
          push_op.kind = utgl_pkg::OP_CLEAR;
          accum_nxt    = '0;
          tails_nxt    = 2'd0;
          err_seen_nxt = 1'b0;
        end
        utgl_pkg::ACT_BYTE: begin
          if (!err_seen_r) begin
            if (tails_r == 2'd0) begin
              if ((in_text_byte & ASCII_MASK) == 8'h00) begin
                push       = 1'b1;
                push_op.cp = CP_W'(in_text_byte);
              end else if ((in_text_byte & LEAD2_MASK) == LEAD2_VAL) begin
                accum_nxt = CP_W'(in_text_byte & LEAD2_BITS);
                tails_nxt = 2'd1;
              end else if ((in_text_byte & LEAD3_MASK) == LEAD3_VAL) begin
                accum_nxt = CP_W'(in_text_byte & LEAD3_BITS);
                tails_nxt = 2'd2;
              end else if ((in_text_byte & LEAD4_MASK) == LEAD4_VAL) begin
                accum_nxt = CP_W'(in_text_byte & LEAD4_BITS);
                tails_nxt = 2'd3;
              end else begin
                err_seen_nxt = 1'b1;
                push         = 1'b1;
                push_op.kind = utgl_pkg::OP_ERR;
              end
            end else if ((in_text_byte & TAIL_MASK) != TAIL_VAL) begin
              err_seen_nxt = 1'b1;
              tails_nxt    = 2'd0;
              push         = 1'b1;
              push_op.kind = utgl_pkg::OP_ERR;
            end else begin
              accum_nxt = tail_acc;
              tails_nxt = tails_r - 2'd1;
              if (tails_r == 2'd1) begin
                push       = 1'b1;
                push_op.cp = tail_acc;
              end
            end
          end
        end
        utgl_pkg::ACT_READ: begin
          push         = 1'b1;
          push_op.kind = utgl_pkg::OP_READ;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    accum_r <= accum_nxt;
    if (!rst_n) begin
      tails_r    <= 2'd0;
      err_seen_r <= 1'b0;
    end else begin
      tails_r    <= tails_nxt;
      err_seen_r <= err_seen_nxt;
    end
  end

endmodule

// ===== hdl/utgl_queue.sv =====
// Short first-in first-out queue of operations between the decoder and the layout
// engine. Depends on utgl_pkg.

module utgl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  utgl_pkg::op_t push_op,
  input  logic          pop,
  output utgl_pkg::op_t head,
  output logic          full,
  output logic          empty
);

  localparam int QDEPTH = utgl_pkg::QDEPTH;
  localparam int QPTR_W = utgl_pkg::QPTR_W;
  localparam int QCNT_W = utgl_pkg::QCNT_W;

  utgl_pkg::op_t     q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_op;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

// ===== hdl/utgl_back.sv =====
// Layout engine of the text grid: owns the grid memory, the cursor and the flags,
// runs the clearing pass, word-wrap moves and cell reads. Depends on utgl_pkg.

module utgl_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [utgl_pkg::COLS_W-1:0]       columns,
  input  logic [utgl_pkg::ROWS_W-1:0]       rows,
  input  logic                              q_empty,
  input  utgl_pkg::op_t                     q_head,
  output logic                              q_pop,
  output utgl_pkg::back_status_t            status,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [utgl_pkg::CP_W-1:0]         out_cell_codepoint,
  output logic                              out_decode_error,
  output logic                              out_grid_full
);

  localparam int COL_W  = utgl_pkg::COL_W;
  localparam int ROW_W  = utgl_pkg::ROW_W;
  localparam int CCOL_W = utgl_pkg::CCOL_W;
  localparam int CROW_W = utgl_pkg::CROW_W;
  localparam int ADDR_W = utgl_pkg::ADDR_W;
  localparam int CMP_W  = utgl_pkg::CMP_W;
  localparam int CP_W   = utgl_pkg::CP_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_CP_RD,
    S_CP_WR1,
    S_CP_WR2,
    S_PLACE,
    S_RD_WAIT
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [CCOL_W-1:0] col_r;
  logic [CCOL_W-1:0] col_nxt;
  logic [CROW_W-1:0] row_r;
  logic [CROW_W-1:0] row_nxt;
  logic              err_r;
  logic              err_nxt;
  logic              full_r;
  logic              full_nxt;
  logic [CP_W-1:0]   cp_r;
  logic [CP_W-1:0]   cp_nxt;
  logic [COL_W-1:0]  p_r;
  logic [COL_W-1:0]  p_nxt;
  logic [COL_W-1:0]  s_r;
  logic [COL_W-1:0]  s_nxt;
  logic [COL_W-1:0]  i_r;
  logic [COL_W-1:0]  i_nxt;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [ADDR_W-1:0] clr_cnt_nxt;
  logic              in_range_r;
  logic              in_range_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [CP_W-1:0]   out_cp_r;
  logic [CP_W-1:0]   out_cp_nxt;
  logic              out_err_r;
  logic              out_err_nxt;
  logic              out_full_r;
  logic              out_full_nxt;

  // Grid memory, one write and one registered read per cycle.
  logic [CP_W-1:0]   grid_mem [2**ADDR_W];
  logic [CP_W-1:0]   rd_data_r;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CP_W-1:0]   wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;

  logic [CCOL_W-1:0] ncols;
  logic [CCOL_W-1:0] ncols_m1;
  logic [CROW_W-1:0] nrows;
  logic [CROW_W-1:0] row_above;
  logic [CCOL_W-1:0] c_col;
  logic [CROW_W-1:0] c_row;
  logic [CROW_W-1:0] c_row_m1;
  logic [CMP_W-1:0]  tab_sum;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return {r, c};
  endfunction

  assign ncols     = utgl_pkg::used_cols(columns);
  assign nrows     = utgl_pkg::used_rows(rows);
  assign ncols_m1  = ncols - CCOL_W'(1);
  assign row_above = row_r - CROW_W'(1);
  assign tab_sum   = CMP_W'(col_r) + CMP_W'(utgl_pkg::TAB_STEP);

  assign status.clearing    = (state_r == S_CLEAR);
  assign out_valid          = out_valid_r;
  assign out_cell_codepoint = out_cp_r;
  assign out_decode_error   = out_err_r;
  assign out_grid_full      = out_full_r;

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    err_nxt       = err_r;
    full_nxt      = full_r;
    cp_nxt        = cp_r;
    p_nxt         = p_r;
    s_nxt         = s_r;
    i_nxt         = i_r;
    clr_cnt_nxt   = clr_cnt_r;
    in_range_nxt  = in_range_r;
    out_cp_nxt    = out_cp_r;
    out_err_nxt   = out_err_r;
    out_full_nxt  = out_full_r;
    out_valid_nxt = out_valid_r & out_stall;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = utgl_pkg::SPACE_CP;
    re            = 1'b0;
    raddr         = '0;
    c_col         = col_r;
    c_row         = row_r;
    c_row_m1      = row_r;

    case (state_r)
      S_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (!q_empty &&
            (q_head.kind != utgl_pkg::OP_READ || !out_valid_r || !out_stall)) begin
          q_pop = 1'b1;
          case (q_head.kind)
            utgl_pkg::OP_CLEAR: begin
              col_nxt     = '0;
              row_nxt     = '0;
              err_nxt     = 1'b0;
              full_nxt    = 1'b0;
              clr_cnt_nxt = '0;
              state_nxt   = S_CLEAR;
            end
            utgl_pkg::OP_ERR: begin
              if (!full_r) begin
                err_nxt = 1'b1;
              end
            end
            utgl_pkg::OP_READ: begin
              re           = 1'b1;
              raddr        = cell_addr(ROW_W'(q_head.row), COL_W'(q_head.col));
              in_range_nxt = (CMP_W'(q_head.col) < CMP_W'(ncols)) &&
                             (CMP_W'(q_head.row) < CMP_W'(nrows));
              state_nxt    = S_RD_WAIT;
            end
            utgl_pkg::OP_CP: begin
              if (!err_r && !full_r) begin
                if (q_head.cp == utgl_pkg::NEWLINE_CP) begin
                  col_nxt = ncols;
                end else if (q_head.cp == utgl_pkg::TAB_CP) begin
                  col_nxt = (tab_sum > CMP_W'(ncols)) ? ncols : CCOL_W'(tab_sum);
                end else begin
                  if (col_r >= ncols) begin
                    c_col = '0;
                    c_row = row_r + CROW_W'(1);
                  end
                  c_row_m1 = c_row - CROW_W'(1);
                  col_nxt  = c_col;
                  row_nxt  = c_row;
                  if (c_row >= nrows) begin
                    full_nxt = 1'b1;
                  end else begin
                    cp_nxt = q_head.cp;
                    if (c_col == '0 && c_row != '0) begin
                      re        = 1'b1;
                      raddr     = cell_addr(c_row_m1[ROW_W-1:0], ncols_m1[COL_W-1:0]);
                      p_nxt     = ncols_m1[COL_W-1:0];
                      state_nxt = S_SCAN;
                    end else begin
                      state_nxt = S_PLACE;
                    end
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_data_r == utgl_pkg::SPACE_CP) begin
          if (CCOL_W'(p_r) == ncols_m1) begin
            state_nxt = S_PLACE;
          end else begin
            s_nxt     = p_r + COL_W'(1);
            i_nxt     = '0;
            state_nxt = S_CP_RD;
          end
        end else if (p_r == '0) begin
          state_nxt = S_PLACE;
        end else begin
          re    = 1'b1;
          raddr = cell_addr(row_above[ROW_W-1:0], p_r - COL_W'(1));
          p_nxt = p_r - COL_W'(1);
        end
      end

      S_CP_RD: begin
        re        = 1'b1;
        raddr     = cell_addr(row_above[ROW_W-1:0], s_r);
        state_nxt = S_CP_WR1;
      end

      S_CP_WR1: begin
        we        = 1'b1;
        waddr     = cell_addr(row_r[ROW_W-1:0], i_r);
        wdata     = rd_data_r;
        state_nxt = S_CP_WR2;
      end

      S_CP_WR2: begin
        we    = 1'b1;
        waddr = cell_addr(row_above[ROW_W-1:0], s_r);
        wdata = utgl_pkg::SPACE_CP;
        if (CCOL_W'(s_r) == ncols_m1) begin
          col_nxt   = CCOL_W'(i_r) + CCOL_W'(1);
          state_nxt = S_PLACE;
        end else begin
          s_nxt     = s_r + COL_W'(1);
          i_nxt     = i_r + COL_W'(1);
          state_nxt = S_CP_RD;
        end
      end

      S_PLACE: begin
        if (cp_r != utgl_pkg::SPACE_CP || col_r != '0) begin
          if (col_r < ncols) begin
            we      = 1'b1;
            waddr   = cell_addr(row_r[ROW_W-1:0], col_r[COL_W-1:0]);
            wdata   = cp_r;
            col_nxt = col_r + CCOL_W'(1);
          end else begin
            col_nxt = ncols;
          end
        end
        state_nxt = S_IDLE;
      end

      S_RD_WAIT: begin
        out_valid_nxt = 1'b1;
        out_cp_nxt    = in_range_r ? rd_data_r : utgl_pkg::SPACE_CP;
        out_err_nxt   = err_r;
        out_full_nxt  = full_r;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      grid_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= grid_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    cp_r       <= cp_nxt;
    p_r        <= p_nxt;
    s_r        <= s_nxt;
    i_r        <= i_nxt;
    in_range_r <= in_range_nxt;
    out_cp_r   <= out_cp_nxt;
    out_err_r  <= out_err_nxt;
    out_full_r <= out_full_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      col_r       <= '0;
      row_r       <= '0;
      err_r       <= 1'b0;
      full_r      <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      err_r       <= err_nxt;
      full_r      <= full_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE)
    else $error("operation taken from the queue outside the idle state");

  a_clear_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.kind == utgl_pkg::OP_CLEAR) |=>
      (state_r == S_CLEAR && !err_r && !full_r && col_r == '0 && row_r == '0))
    else $error("clear did not restart the layout");

  a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_WAIT) |=> out_valid_r)
    else $error("cell read did not load the output register");

  a_wrap_below_top: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_CP_WR1) |-> row_r != '0)
    else $error("word move attempted on the top row");

endmodule

// ===== hdl/utf8_text_grid_layout_wrap.sv =====
// Top level of the UTF-8 text grid layout block with word wrap.
// Holds the configuration registers and joins utgl_front, utgl_queue and utgl_back.
// Depends on utgl_pkg.

// Usage
// Requests arrive on the in_ channel (in_valid / in_stall). Each carries an action:
// clear and restart the layout, one UTF-8 text byte, or a read of one grid cell.
// Only a cell read gives a result, on the out_ channel (out_valid / out_stall), with
// the stored codepoint and the sticky decode-error and grid-full flags.
// A request that yields an operation enters a four-entry queue in the cycle it is
// accepted; the layout engine then works through the queue in order. A cell read
// reads the grid as it leaves the queue and its data then goes to the output register.
// A printable character passes through the placing state; newline, tab and ignored
// bytes are handled in the idle state alone. When a new row begins below another, the
// engine scans that row back from its last cell; if it ends in a word that does not
// fill it, the word moves down a character at a time, each read, written to the new
// row and blanked in the old. After reset, and after every clear request, the engine
// writes spaces through all 2048 grid cells; in_stall stays high during that pass.
// If the receiver holds out_stall, the result waits in the output register while the
// queue keeps filling; in_stall rises only when the queue is full or a pass runs.
// The columns and rows registers are written through cfg_we / cfg_index / cfg_wdata
// and should be changed only while the block is idle.

module utf8_text_grid_layout_wrap (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [utgl_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_action,
  input  logic [utgl_pkg::BYTE_W-1:0]       in_text_byte,
  input  logic [utgl_pkg::CELL_COL_W-1:0]   in_cell_col,
  input  logic [utgl_pkg::CELL_ROW_W-1:0]   in_cell_row,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [utgl_pkg::CP_W-1:0]         out_cell_codepoint,
  output logic                              out_decode_error,
  output logic                              out_grid_full
);

  logic [utgl_pkg::COLS_W-1:0] columns_r;
  logic [utgl_pkg::COLS_W-1:0] columns_nxt;
  logic [utgl_pkg::ROWS_W-1:0] rows_r;
  logic [utgl_pkg::ROWS_W-1:0] rows_nxt;

  logic                   push;
  utgl_pkg::op_t          push_op;
  logic                   q_pop;
  utgl_pkg::op_t          q_head;
  logic                   q_full;
  logic                   q_empty;
  utgl_pkg::back_status_t back_status;

  // Configuration writes; the register index selects which register takes the data.
  always_comb begin
    columns_nxt = columns_r;
    rows_nxt    = rows_r;
    if (cfg_we) begin
      case (cfg_index)
        utgl_pkg::CFG_COLUMNS: columns_nxt = cfg_wdata[utgl_pkg::COLS_W-1:0];
        utgl_pkg::CFG_ROWS:    rows_nxt    = cfg_wdata[utgl_pkg::ROWS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= utgl_pkg::COLUMNS_RESET;
      rows_r    <= utgl_pkg::ROWS_RESET;
    end else begin
      columns_r <= columns_nxt;
      rows_r    <= rows_nxt;
    end
  end

  // The front end decodes bytes as they arrive, so the engine only sees whole
  // codepoints, error marks, clears and reads.
  utgl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_text_byte (in_text_byte),
    .in_cell_col  (in_cell_col),
    .in_cell_row  (in_cell_row),
    .q_full       (q_full),
    .back_status  (back_status),
    .push         (push),
    .push_op      (push_op)
  );

  // The queue lets the front end keep taking requests while the engine is busy
  // moving a word or waiting for the receiver.
  utgl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (q_pop),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  // The engine owns the grid, the cursor and both sticky flags.
  utgl_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .columns            (columns_r),
    .rows               (rows_r),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .status             (back_status),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cell_codepoint (out_cell_codepoint),
    .out_decode_error   (out_decode_error),
    .out_grid_full      (out_grid_full)
  );

endmodule
